/* rtl/core/assert_macros.svh */
// Assertion macros shared by the receiver RTL.
// Every macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/xcfr_pkg.sv */
// Shared types and constants for the XOR-checked frame receiver.
// Used by xcfr_parser, xcfr_link and xor_checked_frame_receiver; has no dependencies.
package xcfr_pkg;

  localparam int MAX_PAYLOAD_BYTES = 8;

  // Item commands.
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_TIME  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_START_BYTE    = 2'd0;
  localparam logic [1:0] REG_END_BYTE      = 2'd1;
  localparam logic [1:0] REG_SILENCE_LIMIT = 2'd2;

  // Configuration reset values.
  localparam logic [7:0]  START_BYTE_RESET    = 8'd170;
  localparam logic [7:0]  END_BYTE_RESET      = 8'd85;
  localparam logic [15:0] SILENCE_LIMIT_RESET = 16'd3000;

  localparam logic [15:0] SILENCE_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_ID    = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4,
    PH_END   = 3'd5
  } xcfr_phase_t;

  typedef enum logic [1:0] {
    LINK_DOWN       = 2'd0,
    LINK_CONNECTING = 2'd1,
    LINK_UP         = 2'd2
  } xcfr_link_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic [9:0] elapsed_ms;
  } xcfr_in_t;

  typedef struct packed {
    logic        frame_done;
    logic        frame_rejected;
    logic [7:0]  frame_id;
    logic [7:0]  frame_length;
    logic [63:0] frame_payload;
    logic [1:0]  link_state;
  } xcfr_out_t;

  // Parser verdict for one item, handed to the link monitor and the result register.
  typedef struct packed {
    logic        done;
    logic        rejected;
    logic [7:0]  id;
    logic [7:0]  length;
    logic [63:0] payload;
  } xcfr_frame_t;

endpackage

/* rtl/core/xcfr_parser.sv */
// Frame parser: walks start, id, length, payload, checksum and end positions.
// Depends on xcfr_pkg.
module xcfr_parser #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [1:0]         command,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         start_byte,
  input  logic [7:0]         end_byte,
  output xcfr_pkg::xcfr_frame_t frame
);
  import xcfr_pkg::*;

  localparam int CntW = $clog2(PAYLOAD_BYTES + 1);
  localparam int IdxW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [CntW-1:0] LastCount = CntW'(PAYLOAD_BYTES - 1);

  xcfr_phase_t     phase, phase_next;
  logic [CntW-1:0] count, count_next;
  logic [7:0]      held_id, held_id_next;
  logic [7:0]      held_length, held_length_next;
  logic [7:0]      running_xor, running_xor_next;
  logic [7:0]      held_check, held_check_next;
  logic [7:0]      held_payload [PAYLOAD_BYTES];
  logic [63:0]     payload_word;
  logic            byte_step;
  logic            end_step;
  logic            frame_ok;

  assign byte_step = step && (command == CMD_BYTE);

  // Next-state logic.
  always_comb begin
    phase_next       = phase;
    count_next       = count;
    held_id_next     = held_id;
    held_length_next = held_length;
    running_xor_next = running_xor;
    held_check_next  = held_check;
    if (step) begin
      case (command)
        CMD_BYTE: begin
          case (phase)
            PH_ID: begin
              held_id_next     = rx_byte;
              running_xor_next = rx_byte;
              phase_next       = PH_LEN;
            end
            PH_LEN: begin
              held_length_next = rx_byte;
              running_xor_next = running_xor ^ rx_byte;
              count_next       = '0;
              phase_next       = PH_DATA;
            end
            PH_DATA: begin
              running_xor_next = running_xor ^ rx_byte;
              count_next       = count + CntW'(1);
              if (count == LastCount) begin
                phase_next = PH_CHECK;
              end
            end
            PH_CHECK: begin
              held_check_next = rx_byte;
              phase_next      = PH_END;
            end
            PH_END: begin
              phase_next = PH_START;
            end
            default: begin
              // Waiting for the start byte; unused phase codes behave the same.
              phase_next = (rx_byte == start_byte) ? PH_ID : PH_START;
            end
          endcase
        end
        CMD_START: begin
          phase_next = PH_START;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      count <= '0;
    end else begin
      phase <= phase_next;
      count <= count_next;
    end
  end

  // Held fields are always rewritten within a frame before they are read.
  always_ff @(posedge clk) begin
    held_id     <= held_id_next;
    held_length <= held_length_next;
    running_xor <= running_xor_next;
    held_check  <= held_check_next;
    if (byte_step && (phase == PH_DATA)) begin
      held_payload[count[IdxW-1:0]] <= rx_byte;
    end
  end

  for (genvar i = 0; i < MAX_PAYLOAD_BYTES; i++) begin : g_pay
    if (i < PAYLOAD_BYTES) begin : g_used
      assign payload_word[8*i +: 8] = held_payload[i];
    end else begin : g_unused
      assign payload_word[8*i +: 8] = 8'h00;
    end
  end

  // Output logic.
  always_comb begin
    end_step       = byte_step && (phase == PH_END);
    frame_ok       = (rx_byte == end_byte) && (running_xor == held_check);
    frame.done     = end_step && frame_ok;
    frame.rejected = end_step && !frame_ok;
    frame.id       = frame.done ? held_id : 8'h00;
    frame.length   = frame.done ? held_length : 8'h00;
    frame.payload  = frame.done ? payload_word : 64'h0;
  end

endmodule

/* rtl/core/xcfr_link.sv */
// Link monitor: silence counter, heard flag and connection state.
// Depends on xcfr_pkg.
module xcfr_link (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [1:0]           command,
  input  logic [9:0]           elapsed_ms,
  input  logic                 frame_done,
  input  logic [15:0]          silence_limit_ms,
  output xcfr_pkg::xcfr_link_t link_state
);
  import xcfr_pkg::*;

  xcfr_link_t  connection, connection_next;
  logic [15:0] silence_ms, silence_ms_next;
  logic        heard_once, heard_once_next;
  logic [16:0] silence_sum;
  logic [15:0] silence_sat;

  assign silence_sum = {1'b0, silence_ms} + {7'd0, elapsed_ms};
  assign silence_sat = silence_sum[16] ? SILENCE_MAX : silence_sum[15:0];

  always_comb begin
    connection_next = connection;
    silence_ms_next = silence_ms;
    heard_once_next = heard_once;
    if (step) begin
      case (command)
        CMD_BYTE: begin
          if (frame_done) begin
            connection_next = LINK_UP;
            heard_once_next = 1'b1;
            silence_ms_next = '0;
          end
        end
        CMD_TIME: begin
          silence_ms_next = silence_sat;
          if ((connection != LINK_DOWN) && heard_once && (silence_sat >= silence_limit_ms)) begin
            connection_next = LINK_DOWN;
          end
        end
        CMD_START: begin
          connection_next = LINK_CONNECTING;
          heard_once_next = 1'b0;
          silence_ms_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      connection <= LINK_DOWN;
      silence_ms <= '0;
      heard_once <= 1'b0;
    end else begin
      connection <= connection_next;
      silence_ms <= silence_ms_next;
      heard_once <= heard_once_next;
    end
  end

  // The result reports the link state after this item.
  assign link_state = connection_next;

endmodule

/* rtl/core/xor_checked_frame_receiver.sv */
// Top level of the XOR-checked frame receiver: input register, parser, link monitor
// and result register. Depends on xcfr_pkg, xcfr_parser, xcfr_link, assert_macros.svh.
//
// Usage:
// Items arrive on in_valid/in_ready/in_item; each one is a received byte, an
// elapsed-time item or a start command. Every accepted item yields exactly one
// result item on out_valid/out_ready/out_item, in order.
// A result reports an accepted frame (id, length and payload), a rejected end
// position, and the link state after the item.
// An item lands in the input register at the edge where it is accepted, and its
// result is written to the output register at the edge where the stage advances.
// The receiver takes one item per cycle while the output is drained; the frame and
// link state update combinationally between the registers, so items need no gap.
// When the receiver stalls, the output register holds its result and the input
// register holds one more item; in_ready falls only when both are full.
// The configuration port (cfg_wen, cfg_index, cfg_wdata) writes the start byte,
// end byte and silence limit; it is meant to be used while no item is in flight.
// Synchronous reset empties both registers, puts the parser at waiting for a start
// byte, the link at disconnected, and restores the default configuration.
`include "assert_macros.svh"

module xor_checked_frame_receiver #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  xcfr_pkg::xcfr_in_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output xcfr_pkg::xcfr_out_t out_item,
  input  logic                cfg_wen,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import xcfr_pkg::*;

  // Configuration registers.
  logic [7:0]  start_byte;
  logic [7:0]  end_byte;
  logic [15:0] silence_limit_ms;

  // Input register stage.
  logic     s1_valid;
  xcfr_in_t s1_item;

  // The stage advances whenever it holds an item and the output register is empty or being drained.
  logic        advance;
  xcfr_frame_t frame;
  xcfr_link_t  link_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte       <= START_BYTE_RESET;
      end_byte         <= END_BYTE_RESET;
      silence_limit_ms <= SILENCE_LIMIT_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_START_BYTE:    start_byte       <= cfg_wdata[7:0];
        REG_END_BYTE:      end_byte         <= cfg_wdata[7:0];
        REG_SILENCE_LIMIT: silence_limit_ms <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  xcfr_parser #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .command    (s1_item.command),
    .rx_byte    (s1_item.rx_byte),
    .start_byte (start_byte),
    .end_byte   (end_byte),
    .frame      (frame)
  );

  xcfr_link u_link (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .command          (s1_item.command),
    .elapsed_ms       (s1_item.elapsed_ms),
    .frame_done       (frame.done),
    .silence_limit_ms (silence_limit_ms),
    .link_state       (link_state)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.frame_done     <= frame.done;
      out_item.frame_rejected <= frame.rejected;
      out_item.frame_id       <= frame.id;
      out_item.frame_length   <= frame.length;
      out_item.frame_payload  <= frame.payload;
      out_item.link_state     <= link_state;
    end
  end

  // A result never reports both an accepted and a rejected frame.
  `ASSERT_SAME_CYCLE(a_done_xor_reject, out_valid,
    !(out_item.frame_done && out_item.frame_rejected), "frame both accepted and rejected")

  // An accepted frame always leaves the link connected.
  `ASSERT_SAME_CYCLE(a_done_link_up, out_valid && out_item.frame_done,
    out_item.link_state == LINK_UP, "accepted frame without connected link")

  // Frame fields are zero unless a frame was accepted.
  `ASSERT_SAME_CYCLE(a_fields_zero, out_valid && !out_item.frame_done,
    (out_item.frame_id == 8'h00) && (out_item.frame_payload == 64'h0), "stale frame fields")

  // An empty output register never blocks the input side.
  `ASSERT_SAME_CYCLE(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

  // A processed item always shows up in the output register on the next cycle.
  `ASSERT_NEXT_CYCLE(a_advance_fills, advance, out_valid, "processed item lost")

endmodule
